/* rtl/ppm6_pkg.sv */
// Shared types and constants for the P6 stream decoder.
// Used by the parser front end, the result queue and the output sequencer.
package ppm6_pkg;

  localparam int unsigned DIM_W    = 13;  // image width / height
  localparam int unsigned ACC_W    = 16;  // decimal accumulator, up to the number limit
  localparam int unsigned RASTER_W = 26;  // raster byte count
  localparam int unsigned CAP_W    = 27;  // capacity register
  localparam int unsigned RGB_W    = 24;

  localparam logic [DIM_W-1:0]  MAX_DIMENSION = DIM_W'(4096);
  localparam logic [19:0]       NUMBER_LIMIT  = 20'd65535;
  localparam logic [ACC_W-1:0]  MAXVAL_REQ    = ACC_W'(255);
  localparam logic [CAP_W-1:0]  CAP_RESET     = CAP_W'(67108864);
  localparam logic [2:0]        HDR_MIN_BYTES = 3'd4;
  localparam logic [7:0]        ALPHA_OPAQUE  = 8'hFF;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [3:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_MAGIC_SPACE,
    PH_SKIP_W,
    PH_NUM_W,
    PH_SKIP_H,
    PH_NUM_H,
    PH_SKIP_M,
    PH_NUM_M,
    PH_RASTER,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_CAPACITY    = 2'd3
  } status_e;

  // One queue entry: what a single accepted byte asks the back end to emit.
  typedef struct packed {
    logic             pix_valid;
    logic [RGB_W-1:0] rgb;
    logic             stat_valid;
    status_e          status;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } entry_t;

endpackage

/* rtl/ppm6_p6_stream_decoder_top.sv */
// Binary PPM (P6) stream decoder, top level.
// Joins ppm6_front, ppm6_queue and ppm6_back; types from ppm6_pkg.
//
// Feed the file one byte per beat on the input channel, raising
// last_byte_i on the final byte. The block takes one byte every clock
// cycle, and the front end only stalls when the four-entry result queue
// is full. Each complete RGB triple of the raster yields one pixel beat
// (RGBA, alpha 0xFF) unless the image is too big for capacity_bytes; the
// last byte yields a status beat carrying the parsed size when the status
// is OK. A byte that both completes a pixel and ends the file yields two
// beats, which the output sequencer sends one after the other, pixel first;
// the queue soaks that up, so sustained input rate stays at one byte per
// cycle while the output side keeps pace. An accepted byte's result is
// written into the queue and from there loaded into the output register.
// Treat all pixels as tentative until the status beat reports OK. Write
// the capacity register only while the block is idle; the port always
// accepts.
module ppm_p6_stream_decoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ppm6_pkg::CAP_W-1:0]  cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        is_status_o,
  output logic [31:0]                 pixel_rgba_o,
  output logic [1:0]                  status_o,
  output logic [ppm6_pkg::DIM_W-1:0]  image_width_o,
  output logic [ppm6_pkg::DIM_W-1:0]  image_height_o
);
  import ppm6_pkg::*;

  logic    q_push, q_full, q_pop, q_empty;
  entry_t  q_push_entry, q_head;

  // Parse and classify bytes, hold the capacity register.
  ppm6_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_push_entry)
  );

  // Decouple parser from the output handshake.
  ppm6_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .empty_o      (q_empty)
  );

  // Turn entries into pixel and status beats.
  ppm6_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_status_o    (is_status_o),
    .pixel_rgba_o   (pixel_rgba_o),
    .status_o       (status_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

endmodule

/* rtl/ppm6_front.sv */
// Front end of the P6 stream decoder: header parser, raster tracker and
// capacity register. Depends on ppm6_pkg; feeds entries to ppm6_queue.
module ppm6_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ppm6_pkg::CAP_W-1:0]  cfg_data_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output ppm6_pkg::entry_t            q_entry_o
);
  import ppm6_pkg::*;

  phase_e                phase_q, phase_d;
  logic [ACC_W-1:0]      accum_q, accum_d;
  logic                  ovf_q, ovf_d;
  logic                  cmt_q, cmt_d;
  logic [DIM_W-1:0]      width_q, width_d;
  logic [DIM_W-1:0]      height_q, height_d;
  logic [2:0]            hb_q, hb_d;
  logic [1:0]            ci_q, ci_d;
  logic [15:0]           held_q, held_d;
  logic [RASTER_W-1:0]   rc_q, rc_d;
  logic [RASTER_W-1:0]   exp_q, exp_d;
  logic                  fits_q, fits_d;
  logic [RASTER_W-1:0]   px_q;
  logic [CAP_W-1:0]      cap_q;

  logic                  acc;
  logic                  is_sp, is_dg;
  logic [3:0]            dig;
  logic [19:0]           mac;
  logic                  dim_ok;
  logic                  do_skip;
  phase_e                skip_num;
  status_e               st;

  assign acc         = in_valid_i && !q_full_i;
  assign in_stall_o  = q_full_i;
  assign cfg_ready_o = 1'b1;

  assign is_sp = (data_byte_i == CH_TAB) || (data_byte_i == CH_LF) ||
                 (data_byte_i == CH_CR) || (data_byte_i == CH_SPACE);
  assign is_dg = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign dig   = data_byte_i[3:0];
  // accum * 10 + digit, by shifts
  assign mac   = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {16'b0, dig};
  assign dim_ok = !ovf_q && (accum_q != '0) && (accum_q <= ACC_W'(MAX_DIMENSION));

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    ovf_d     = ovf_q;
    cmt_d     = cmt_q;
    width_d   = width_q;
    height_d  = height_q;
    hb_d      = hb_q;
    ci_d      = ci_q;
    held_d    = held_q;
    rc_d      = rc_q;
    exp_d     = exp_q;
    fits_d    = fits_q;
    do_skip   = 1'b0;
    skip_num  = PH_NUM_W;
    st        = ST_OK;
    q_push_o  = 1'b0;
    q_entry_o = '0;

    if (acc) begin
      if (hb_q < HDR_MIN_BYTES) begin
        hb_d = hb_q + 3'd1;
      end

      if (phase_q == PH_RASTER) begin
        if (rc_q < exp_q) begin
          rc_d = rc_q + RASTER_W'(1);
          if (ci_q < 2'd2) begin
            held_d = {held_q[7:0], data_byte_i};
            ci_d   = ci_q + 2'd1;
          end else begin
            ci_d   = 2'd0;
            held_d = '0;
            if (fits_q) begin
              q_entry_o.pix_valid = 1'b1;
              q_entry_o.rgb       = {held_q, data_byte_i};
            end
          end
        end else begin
          rc_d = exp_q + RASTER_W'(1);
        end
      end else if (phase_q != PH_ERROR) begin
        if (is_dg && ((phase_q == PH_NUM_W) || (phase_q == PH_NUM_H) ||
                      (phase_q == PH_NUM_M))) begin
          if (ovf_q || (mac > NUMBER_LIMIT)) begin
            ovf_d = 1'b1;
          end else begin
            accum_d = mac[ACC_W-1:0];
          end
        end else begin
          case (phase_q)
            PH_MAGIC0: begin
              phase_d = (data_byte_i == CH_P) ? PH_MAGIC1 : PH_ERROR;
            end
            PH_MAGIC1: begin
              phase_d = (data_byte_i == CH_SIX) ? PH_MAGIC_SPACE : PH_ERROR;
            end
            PH_MAGIC_SPACE: begin
              phase_d = is_sp ? PH_SKIP_W : PH_ERROR;
            end
            PH_SKIP_W: begin
              do_skip  = 1'b1;
              skip_num = PH_NUM_W;
            end
            PH_NUM_W: begin
              if (!dim_ok) begin
                phase_d = PH_ERROR;
              end else begin
                width_d  = accum_q[DIM_W-1:0];
                phase_d  = PH_SKIP_H;
                do_skip  = 1'b1;
                skip_num = PH_NUM_H;
              end
            end
            PH_SKIP_H: begin
              do_skip  = 1'b1;
              skip_num = PH_NUM_H;
            end
            PH_NUM_H: begin
              if (!dim_ok) begin
                phase_d = PH_ERROR;
              end else begin
                height_d = accum_q[DIM_W-1:0];
                phase_d  = PH_SKIP_M;
                do_skip  = 1'b1;
                skip_num = PH_NUM_M;
              end
            end
            PH_SKIP_M: begin
              do_skip  = 1'b1;
              skip_num = PH_NUM_M;
            end
            PH_NUM_M: begin
              if (ovf_q || (accum_q != MAXVAL_REQ) || !is_sp) begin
                phase_d = PH_ERROR;
              end else begin
                // px_q has settled: maxval needs several bytes after height
                exp_d   = {px_q[RASTER_W-2:0], 1'b0} + px_q;
                fits_d  = ({px_q, 2'b00} <= {1'b0, cap_q});
                rc_d    = '0;
                ci_d    = 2'd0;
                held_d  = '0;
                phase_d = PH_RASTER;
              end
            end
            default: begin
              phase_d = PH_ERROR;
            end
          endcase

          if (do_skip) begin
            if (cmt_q) begin
              if ((data_byte_i == CH_LF) || (data_byte_i == CH_CR)) begin
                cmt_d = 1'b0;
              end else if ((data_byte_i < CH_SPACE) && (data_byte_i != CH_TAB)) begin
                phase_d = PH_ERROR;
              end
            end else if (is_sp) begin
              // stay in the skip phase
            end else if (data_byte_i == CH_HASH) begin
              cmt_d = 1'b1;
            end else if (is_dg) begin
              accum_d = ACC_W'(dig);
              ovf_d   = 1'b0;
              phase_d = skip_num;
            end else begin
              phase_d = PH_ERROR;
            end
          end
        end
      end

      if (last_byte_i) begin
        if (hb_d < HDR_MIN_BYTES) begin
          st = ST_INVALID;
        end else if ((phase_d != PH_RASTER) || (rc_d != exp_d)) begin
          st = ST_UNSUPPORTED;
        end else if (!fits_d) begin
          st = ST_CAPACITY;
        end else begin
          st = ST_OK;
        end
        q_entry_o.stat_valid = 1'b1;
        q_entry_o.status     = st;
        q_entry_o.width      = (st == ST_OK) ? width_d : '0;
        q_entry_o.height     = (st == ST_OK) ? height_d : '0;

        // drop the run state, keep the capacity
        phase_d  = PH_MAGIC0;
        accum_d  = '0;
        ovf_d    = 1'b0;
        cmt_d    = 1'b0;
        width_d  = '0;
        height_d = '0;
        hb_d     = '0;
        ci_d     = '0;
        held_d   = '0;
        rc_d     = '0;
        exp_d    = '0;
        fits_d   = 1'b0;
      end

      q_push_o = q_entry_o.pix_valid || q_entry_o.stat_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC0;
      accum_q  <= '0;
      ovf_q    <= 1'b0;
      cmt_q    <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      hb_q     <= '0;
      ci_q     <= '0;
      held_q   <= '0;
      rc_q     <= '0;
      exp_q    <= '0;
      fits_q   <= 1'b0;
      cap_q    <= CAP_RESET;
    end else begin
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      ovf_q    <= ovf_d;
      cmt_q    <= cmt_d;
      width_q  <= width_d;
      height_q <= height_d;
      hb_q     <= hb_d;
      ci_q     <= ci_d;
      held_q   <= held_d;
      rc_q     <= rc_d;
      exp_q    <= exp_d;
      fits_q   <= fits_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Pixel count of the image, registered off the multiplier.
  always_ff @(posedge clk_i) begin
    px_q <= RASTER_W'(width_q) * RASTER_W'(height_q);
  end

endmodule

/* rtl/ppm6_queue.sv */
// Short result queue between the decoder front end and the output sequencer.
// Register-based ring of entry_t from ppm6_pkg.
module ppm6_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ppm6_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output ppm6_pkg::entry_t head_o,
  output logic             empty_o
);
  import ppm6_pkg::*;

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* rtl/ppm6_back.sv */
// Output sequencer of the P6 stream decoder: splits queue entries into
// pixel and status beats held in the output register. Depends on ppm6_pkg.
module ppm6_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  ppm6_pkg::entry_t            q_head_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        is_status_o,
  output logic [31:0]                 pixel_rgba_o,
  output logic [1:0]                  status_o,
  output logic [ppm6_pkg::DIM_W-1:0]  image_width_o,
  output logic [ppm6_pkg::DIM_W-1:0]  image_height_o
);
  import ppm6_pkg::*;

  logic              valid_q, valid_d;
  logic              pix_done_q, pix_done_d;
  logic              load;
  logic              is_status_q, is_status_d;
  logic [31:0]       pixel_q, pixel_d;
  logic [1:0]        status_q, status_d;
  logic [DIM_W-1:0]  width_q, width_d;
  logic [DIM_W-1:0]  height_q, height_d;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d     = valid_q;
    pix_done_d  = pix_done_q;
    is_status_d = is_status_q;
    pixel_d     = pixel_q;
    status_d    = status_q;
    width_d     = width_q;
    height_d    = height_q;
    q_pop_o     = 1'b0;

    if (load) begin
      valid_d = 1'b0;
      if (!q_empty_i) begin
        valid_d = 1'b1;
        if (q_head_i.pix_valid && !pix_done_q) begin
          is_status_d = 1'b0;
          pixel_d     = {q_head_i.rgb, ALPHA_OPAQUE};
          status_d    = ST_OK;
          width_d     = '0;
          height_d    = '0;
          // hold the entry if its status beat is still to come
          if (q_head_i.stat_valid) begin
            pix_done_d = 1'b1;
          end else begin
            q_pop_o = 1'b1;
          end
        end else begin
          is_status_d = 1'b1;
          pixel_d     = '0;
          status_d    = q_head_i.status;
          width_d     = q_head_i.width;
          height_d    = q_head_i.height;
          pix_done_d  = 1'b0;
          q_pop_o     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      pix_done_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      pix_done_q <= pix_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_status_q <= is_status_d;
    pixel_q     <= pixel_d;
    status_q    <= status_d;
    width_q     <= width_d;
    height_q    <= height_d;
  end

  assign out_valid_o    = valid_q;
  assign is_status_o    = is_status_q;
  assign pixel_rgba_o   = pixel_q;
  assign status_o       = status_q;
  assign image_width_o  = width_q;
  assign image_height_o = height_q;

endmodule
